### rtl/bbc_pkg.sv
// ---------------------------------------------------------------------------
// bbc_pkg
// Shared types, status codes and bracket tables for the bracket balance
// checker.
// ---------------------------------------------------------------------------
package bbc_pkg;

	// bracket kind held by one stack cell
	typedef logic [1:0] kind_t;

	localparam kind_t KIND_PAREN = 2'd0;
	localparam kind_t KIND_BRACE = 2'd1;
	localparam kind_t KIND_SQUARE = 2'd2;
	localparam kind_t KIND_ANGLE = 2'd3;

	// report codes
	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BALANCED = 3'd1,
		ST_MISSING = 3'd2,
		ST_WRONG = 3'd3,
		ST_UNCLOSED = 3'd4,
		ST_OVERFLOW = 3'd5,
		ST_IGNORED = 3'd6
	} status_t;

	localparam int POS_W = 12;
	localparam logic [POS_W-1:0] POS_MAX = 12'd4095;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_OPEN_PAREN = 8'h28;
	localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
	localparam logic [7:0] CH_OPEN_BRACE = 8'h7b;
	localparam logic [7:0] CH_CLOSE_BRACE = 8'h7d;
	localparam logic [7:0] CH_OPEN_SQUARE = 8'h5b;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5d;
	localparam logic [7:0] CH_OPEN_ANGLE = 8'h3c;
	localparam logic [7:0] CH_CLOSE_ANGLE = 8'h3e;

	// shift command shared by every cell of the stack chain
	typedef struct packed {
		logic push;
		logic pop;
	} stack_op_t;

	// opener character of a kind
	function automatic logic [7:0] open_char(input kind_t k);
		logic [7:0] c;
		case (k)
			KIND_PAREN: c = CH_OPEN_PAREN;
			KIND_BRACE: c = CH_OPEN_BRACE;
			KIND_SQUARE: c = CH_OPEN_SQUARE;
			default: c = CH_OPEN_ANGLE;
		endcase
		return c;
	endfunction

	// closer character of a kind
	function automatic logic [7:0] close_char(input kind_t k);
		logic [7:0] c;
		case (k)
			KIND_PAREN: c = CH_CLOSE_PAREN;
			KIND_BRACE: c = CH_CLOSE_BRACE;
			KIND_SQUARE: c = CH_CLOSE_SQUARE;
			default: c = CH_CLOSE_ANGLE;
		endcase
		return c;
	endfunction

endpackage

### rtl/bbc_cell.sv
// ---------------------------------------------------------------------------
// bbc_cell
// One entry of the shifting bracket stack. On a push it takes the kind of
// its upper neighbor, on a pop the kind of its lower neighbor.
// ---------------------------------------------------------------------------
module bbc_cell
	import bbc_pkg::*;
(
	input logic clk,
	input stack_op_t op,
	input kind_t kind_above,
	input kind_t kind_below,
	output kind_t kind
);

	kind_t kind_q;

	// shift toward the bottom on push, toward the top on pop
	always_ff @(posedge clk) begin
		if (op.push) begin
			kind_q <= kind_above;
		end else if (op.pop) begin
			kind_q <= kind_below;
		end
	end

	assign kind = kind_q;

endmodule

### rtl/bracket_balance_checker_core.sv
// A result appears in the cycle after its character transfer.
// Throughput: one character per cycle unless a result is stalled; the top of
// stack is always cell 0 of the shifting cell chain, so each push or pop is a
// single shift of the chain. Reset clears stack depth, position, error flag
// and result valid; the stack cells are not reset and are read only below the depth.
// ---------------------------------------------------------------------------
// bracket_balance_checker_core
// Checks one text line for balanced brackets, one character per transfer,
// using a chain of shifting stack cells with the top at cell 0.
// ---------------------------------------------------------------------------
module bracket_balance_checker_core
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic char_valid,
	output logic char_stall,
	input logic [7:0] character,
	input logic last_char,
	output logic result_valid,
	input logic result_stall,
	output logic [2:0] status,
	output logic [POS_W-1:0] position,
	output logic [7:0] expected_char,
	output logic line_done
);

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

	logic [DEPTH_W-1:0] depth_q;
	logic [POS_W-1:0] pos_q;
	logic err_q;
	logic result_valid_q;
	status_t status_q;
	logic [POS_W-1:0] position_q;
	logic [7:0] expected_q;
	logic line_done_q;

	kind_t cell_kind [STACK_DEPTH];
	kind_t push_kind;
	stack_op_t op;

	logic char_accept;
	logic ko_hit;
	logic kc_hit;
	kind_t ko;
	kind_t kc;
	kind_t top_kind;
	kind_t top_after;
	logic [DEPTH_W-1:0] depth_after;
	logic [POS_W-1:0] pos_next;
	logic err_now;
	logic do_push;
	logic do_pop;
	status_t status_d;
	logic [7:0] expected_d;

	// transfer handshake: output register frees when its result is taken
	assign char_stall = result_valid_q & result_stall;
	assign char_accept = char_valid & ~char_stall;

	// bracket decode
	always_comb begin
		ko_hit = 1'b1;
		ko = KIND_PAREN;
		case (character)
			CH_OPEN_PAREN: ko = KIND_PAREN;
			CH_OPEN_BRACE: ko = KIND_BRACE;
			CH_OPEN_SQUARE: ko = KIND_SQUARE;
			CH_OPEN_ANGLE: ko = KIND_ANGLE;
			default: ko_hit = 1'b0;
		endcase
		kc_hit = 1'b1;
		kc = KIND_PAREN;
		case (character)
			CH_CLOSE_PAREN: kc = KIND_PAREN;
			CH_CLOSE_BRACE: kc = KIND_BRACE;
			CH_CLOSE_SQUARE: kc = KIND_SQUARE;
			CH_CLOSE_ANGLE: kc = KIND_ANGLE;
			default: kc_hit = 1'b0;
		endcase
	end

	assign top_kind = cell_kind[0];

	// check one character against the top of stack
	always_comb begin
		status_d = ST_OK;
		expected_d = CH_NUL;
		err_now = 1'b0;
		do_push = 1'b0;
		do_pop = 1'b0;
		if (err_q) begin
			status_d = ST_IGNORED;
		end else begin
			if (ko_hit) begin
				if (depth_q == DEPTH_FULL) begin
					status_d = ST_OVERFLOW;
					err_now = 1'b1;
				end else begin
					do_push = 1'b1;
				end
			end else if (kc_hit) begin
				if (depth_q == '0) begin
					status_d = ST_MISSING;
					expected_d = open_char(kc);
					err_now = 1'b1;
				end else if (top_kind == kc) begin
					do_pop = 1'b1;
				end else begin
					status_d = ST_WRONG;
					expected_d = close_char(top_kind);
					err_now = 1'b1;
				end
			end
			if (last_char && !err_now) begin
				if (depth_after != '0) begin
					status_d = ST_UNCLOSED;
					expected_d = close_char(top_after);
				end else begin
					status_d = ST_BALANCED;
					expected_d = CH_NUL;
				end
			end
		end
	end

	// stack state after this character
	always_comb begin
		if (do_push) begin
			depth_after = depth_q + 1'b1;
			top_after = ko;
		end else if (do_pop) begin
			depth_after = depth_q - 1'b1;
			top_after = cell_kind[1];
		end else begin
			depth_after = depth_q;
			top_after = top_kind;
		end
	end

	assign pos_next = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;

	assign op.push = char_accept & do_push;
	assign op.pop = char_accept & do_pop;
	assign push_kind = ko;

	// stack cell chain, top at index zero
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		kind_t above;
		kind_t below;
		if (i == 0) begin : g_top
			assign above = push_kind;
		end else begin : g_mid
			assign above = cell_kind[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bottom
			assign below = cell_kind[i];
		end else begin : g_inner
			assign below = cell_kind[i+1];
		end
		bbc_cell u_cell (
			.clk(clk),
			.op(op),
			.kind_above(above),
			.kind_below(below),
			.kind(cell_kind[i])
		);
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			pos_q <= '0;
			err_q <= 1'b0;
		end else if (char_accept) begin
			if (last_char) begin
				depth_q <= '0;
				pos_q <= '0;
				err_q <= 1'b0;
			end else begin
				depth_q <= depth_after;
				pos_q <= pos_next;
				err_q <= err_q | err_now;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (char_accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (char_accept) begin
			status_q <= status_d;
			position_q <= pos_next;
			expected_q <= expected_d;
			line_done_q <= last_char;
		end
	end

	assign result_valid = result_valid_q;
	assign status = status_q;
	assign position = position_q;
	assign expected_char = expected_q;
	assign line_done = line_done_q;

`ifndef ASSERT_OFF
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_FULL)
		else $error("stack depth beyond capacity");

	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		char_accept && last_char |=> depth_q == '0 && pos_q == '0 && !err_q)
		else $error("line state not cleared at line end");

	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		op.push |=> cell_kind[0] == $past(push_kind))
		else $error("pushed kind not at top of stack");

	a_expect_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status_q == ST_OK || status_q == ST_BALANCED ||
		status_q == ST_OVERFLOW || status_q == ST_IGNORED) |-> expected_q == CH_NUL)
		else $error("expected character set for a plain status");
`endif

endmodule
